FILE: rtl/dfs_pkg.sv
// shared types and constants for the delimited field splitter
`timescale 1ns / 1ps

package dfs_pkg;

  localparam int unsigned MAX_FIELDS_N = 16;
  localparam int unsigned LINE_BYTES   = 4096;

  // port widths
  localparam int unsigned FIELD_INDEX_W = 4;
  localparam int unsigned START_POS_W   = 12;
  localparam int unsigned FIELD_LEN_W   = 13;

  // internal widths
  localparam int unsigned POS_W  = $clog2(LINE_BYTES);
  localparam int unsigned LPOS_W = $clog2(LINE_BYTES + 1);
  localparam int unsigned CNT_W  = $clog2(MAX_FIELDS_N);

  localparam logic [7:0] QUOTE_BYTE      = 8'h22;
  localparam logic [7:0] DELIMITER_RESET = 8'd44;
  localparam logic [1:0] QUOTE_RUN_LAST  = 2'd2;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic [FIELD_INDEX_W-1:0] field_index;
    logic [START_POS_W-1:0]   start_pos;
    logic [FIELD_LEN_W-1:0]   field_length;
    logic                     last_field;
    logic                     unclosed_quote;
  } result_t;

endpackage

FILE: rtl/dfs_in_reg.sv
// input register holding one request until the scanner takes it
`timescale 1ns / 1ps

module dfs_in_reg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  dfs_pkg::item_t item_i,
  input  logic          take_i,
  output logic          valid_o,
  output dfs_pkg::item_t item_o
);

  logic           valid_q, valid_d;
  dfs_pkg::item_t item_q;
  logic           load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: rtl/dfs_scan.sv
// field scanner: delimiter register, per-line state and result forming
`timescale 1ns / 1ps

module dfs_scan (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  input  logic [7:0]       cfg_delimiter_i,
  input  logic             item_valid_i,
  input  dfs_pkg::item_t   item_i,
  input  logic             space_i,
  output logic             take_o,
  output logic             res_valid_o,
  output dfs_pkg::result_t res_o
);

  typedef enum logic [2:0] {
    MODE_START,
    MODE_PLAIN,
    MODE_QUOTED,
    MODE_AFTER,
    MODE_DONE
  } mode_e;

  logic [7:0]                  delimiter_q, delimiter_d;
  logic [dfs_pkg::LPOS_W-1:0]  line_pos_q, line_pos_d;
  logic [dfs_pkg::CNT_W-1:0]   field_count_q, field_count_d;
  mode_e                       mode_q, mode_d;
  logic [1:0]                  quote_run_q, quote_run_d;
  logic [dfs_pkg::POS_W-1:0]   content_start_q, content_start_d;
  logic [dfs_pkg::LPOS_W-1:0]  content_end_q, content_end_d;
  logic                        seen_text_q, seen_text_d;

  logic                        emit;
  logic                        advance;
  logic                        unclosed;
  logic [dfs_pkg::LPOS_W-1:0]  span;

  always_comb begin
    logic [7:0]                 b;
    logic [dfs_pkg::POS_W-1:0]  pos;
    logic [dfs_pkg::LPOS_W-1:0] pos_next;
    logic                       blank;

    b        = item_i.byte_value;
    pos      = line_pos_q[dfs_pkg::POS_W-1:0];
    pos_next = dfs_pkg::LPOS_W'(pos) + dfs_pkg::LPOS_W'(1);
    blank    = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));

    delimiter_d     = cfg_valid_i ? cfg_delimiter_i : delimiter_q;
    line_pos_d      = line_pos_q;
    field_count_d   = field_count_q;
    mode_d          = mode_q;
    quote_run_d     = quote_run_q;
    content_start_d = content_start_q;
    content_end_d   = content_end_q;
    seen_text_d     = seen_text_q;
    emit            = 1'b0;

    if (item_i.kind == dfs_pkg::KIND_END) begin
      emit            = 1'b1;
      line_pos_d      = '0;
      field_count_d   = '0;
      mode_d          = MODE_START;
      quote_run_d     = '0;
      content_start_d = '0;
      content_end_d   = '0;
      seen_text_d     = 1'b0;
    end else if (line_pos_q < dfs_pkg::LPOS_W'(dfs_pkg::LINE_BYTES)) begin
      line_pos_d = line_pos_q + dfs_pkg::LPOS_W'(1);
      case (mode_q)
        MODE_DONE: begin
        end
        MODE_QUOTED: begin
          if (b == dfs_pkg::QUOTE_BYTE) begin
            if (quote_run_q == dfs_pkg::QUOTE_RUN_LAST) begin
              quote_run_d = '0;
              mode_d      = MODE_AFTER;
            end else begin
              quote_run_d = quote_run_q + 2'd1;
            end
          end else begin
            // a short quote run inside quotes is content
            if (quote_run_q != 2'd0) begin
              if (!seen_text_d) begin
                content_start_d = pos - dfs_pkg::POS_W'(quote_run_q);
                seen_text_d     = 1'b1;
              end
              content_end_d = dfs_pkg::LPOS_W'(pos);
              quote_run_d   = '0;
            end
            if (!blank) begin
              if (!seen_text_d) begin
                content_start_d = pos;
                seen_text_d     = 1'b1;
              end
              content_end_d = pos_next;
            end
          end
        end
        default: begin
          if (b == delimiter_q) begin
            if (field_count_q == dfs_pkg::CNT_W'(dfs_pkg::MAX_FIELDS_N - 1)) begin
              // last allowed field is held until end of line
              mode_d = MODE_DONE;
            end else begin
              emit            = 1'b1;
              field_count_d   = field_count_q + dfs_pkg::CNT_W'(1);
              mode_d          = MODE_START;
              quote_run_d     = '0;
              content_start_d = '0;
              content_end_d   = '0;
              seen_text_d     = 1'b0;
            end
          end else if (mode_q == MODE_AFTER) begin
          end else if (mode_q == MODE_START && b == dfs_pkg::QUOTE_BYTE) begin
            if (!seen_text_q) begin
              content_start_d = pos;
              seen_text_d     = 1'b1;
            end
            content_end_d = pos_next;
            if (quote_run_q == dfs_pkg::QUOTE_RUN_LAST) begin
              quote_run_d     = '0;
              seen_text_d     = 1'b0;
              content_start_d = '0;
              content_end_d   = '0;
              mode_d          = MODE_QUOTED;
            end else begin
              quote_run_d = quote_run_q + 2'd1;
            end
          end else begin
            if (mode_q == MODE_START) begin
              quote_run_d = '0;
              mode_d      = MODE_PLAIN;
            end
            if (!blank) begin
              if (!seen_text_q) begin
                content_start_d = pos;
                seen_text_d     = 1'b1;
              end
              content_end_d = pos_next;
            end
          end
        end
      endcase
    end
  end

  // bytes that close no field never wait on the output side
  assign advance     = item_valid_i && (!emit || space_i);
  assign take_o      = advance;
  assign res_valid_o = advance && emit;

  assign unclosed = (item_i.kind == dfs_pkg::KIND_END) && (mode_q == MODE_QUOTED);
  assign span     = content_end_q - dfs_pkg::LPOS_W'(content_start_q);

  always_comb begin
    res_o.field_index    = dfs_pkg::FIELD_INDEX_W'(field_count_q);
    res_o.last_field     = item_i.kind;
    res_o.unclosed_quote = unclosed;
    if (seen_text_q && !unclosed) begin
      res_o.start_pos    = dfs_pkg::START_POS_W'(content_start_q);
      res_o.field_length = dfs_pkg::FIELD_LEN_W'(span);
    end else begin
      res_o.start_pos    = '0;
      res_o.field_length = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delimiter_q     <= dfs_pkg::DELIMITER_RESET;
      line_pos_q      <= '0;
      field_count_q   <= '0;
      mode_q          <= MODE_START;
      quote_run_q     <= '0;
      content_start_q <= '0;
      content_end_q   <= '0;
      seen_text_q     <= 1'b0;
    end else begin
      delimiter_q <= delimiter_d;
      if (advance) begin
        line_pos_q      <= line_pos_d;
        field_count_q   <= field_count_d;
        mode_q          <= mode_d;
        quote_run_q     <= quote_run_d;
        content_start_q <= content_start_d;
        content_end_q   <= content_end_d;
        seen_text_q     <= seen_text_d;
      end
    end
  end

endmodule

FILE: rtl/dfs_out_reg.sv
// result register between the scanner and the output channel
`timescale 1ns / 1ps

module dfs_out_reg (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             res_valid_i,
  input  dfs_pkg::result_t res_i,
  output logic             space_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output dfs_pkg::result_t res_o
);

  logic             valid_q, valid_d;
  dfs_pkg::result_t res_q;

  assign space_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_valid_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

FILE: rtl/delimited_field_splitter.sv
// Delimited field splitter: takes one line byte or end-of-line request per cycle and reports
// each field as a trimmed start position and length. Sustained rate is one request per clock;
// a request passes an input register and the scanner, and its result is held in the result
// register that drives the output. The only stall is a field-closing request (delimiter or end
// of line) meeting a full, unread result register; other bytes keep flowing. The delimiter is
// written through the cfg channel, which is always ready; write it only between lines.
`timescale 1ns / 1ps

module delimited_field_splitter (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [7:0]                          cfg_delimiter_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                kind_i,
  input  logic [7:0]                          byte_value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dfs_pkg::FIELD_INDEX_W-1:0]   field_index_o,
  output logic [dfs_pkg::START_POS_W-1:0]     start_pos_o,
  output logic [dfs_pkg::FIELD_LEN_W-1:0]     field_length_o,
  output logic                                last_field_o,
  output logic                                unclosed_quote_o
);

  dfs_pkg::item_t   in_item;
  dfs_pkg::item_t   held_item;
  dfs_pkg::result_t scan_res;
  dfs_pkg::result_t out_res;
  logic             held_valid;
  logic             take;
  logic             res_valid;
  logic             space;

  assign cfg_ready_o        = 1'b1;
  assign in_item.kind       = kind_i;
  assign in_item.byte_value = byte_value_i;

  dfs_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  dfs_scan u_scan (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_delimiter_i (cfg_delimiter_i),
    .item_valid_i    (held_valid),
    .item_i          (held_item),
    .space_i         (space),
    .take_o          (take),
    .res_valid_o     (res_valid),
    .res_o           (scan_res)
  );

  dfs_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (scan_res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign field_index_o    = out_res.field_index;
  assign start_pos_o      = out_res.start_pos;
  assign field_length_o   = out_res.field_length;
  assign last_field_o     = out_res.last_field;
  assign unclosed_quote_o = out_res.unclosed_quote;

endmodule

FILE: rtl/dfs_checker.sv
// port-level checks for the delimited field splitter, bound to the top level
`timescale 1ns / 1ps

module dfs_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [dfs_pkg::FIELD_INDEX_W-1:0] field_index_o,
  input logic [dfs_pkg::START_POS_W-1:0]   start_pos_o,
  input logic [dfs_pkg::FIELD_LEN_W-1:0]   field_length_o,
  input logic                              last_field_o,
  input logic                              unclosed_quote_o
);

  logic [dfs_pkg::FIELD_LEN_W:0] field_top;

  assign field_top = (dfs_pkg::FIELD_LEN_W + 1)'(start_pos_o)
                   + (dfs_pkg::FIELD_LEN_W + 1)'(field_length_o);

  // a stalled result keeps its valid and payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(field_index_o)
      && $stable(start_pos_o) && $stable(field_length_o)
      && $stable(last_field_o) && $stable(unclosed_quote_o))
    else $error("result changed while stalled");

  // a fresh result is traced back to an accepted request on the input
  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_valid_i && in_ready_o, 2))
    else $error("result without a request");

  // an unclosed quote reports an empty field at end of line
  a_unclosed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && unclosed_quote_o |-> last_field_o && start_pos_o == '0
      && field_length_o == '0)
    else $error("bad unclosed quote result");

  // a field never reaches past the line buffer
  a_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> field_top <= (dfs_pkg::FIELD_LEN_W + 1)'(dfs_pkg::LINE_BYTES))
    else $error("field out of line bounds");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind delimited_field_splitter dfs_checker u_dfs_checker (.*);

FILE: dv/tb.sv
// testbench for the delimited field splitter: directed and random lines against a field predictor
`timescale 1ns / 1ps

module tb;

  localparam int unsigned QUOTE_LEN  = 3;
  localparam int unsigned IDLE_LIMIT = 4000;

  typedef enum logic [2:0] {
    SCAN_START,
    SCAN_PLAIN,
    SCAN_QUOTED,
    SCAN_AFTER,
    SCAN_DONE
  } scan_e;

  logic                              clk_i = 1'b0;
  logic                              rst_ni = 1'b0;
  logic                              cfg_valid_i = 1'b0;
  logic                              cfg_ready_o;
  logic [7:0]                        cfg_delimiter_i = 8'd0;
  logic                              in_valid_i = 1'b0;
  logic                              in_ready_o;
  logic                              kind_i = dfs_pkg::KIND_BYTE;
  logic [7:0]                        byte_value_i = 8'd0;
  logic                              out_valid_o;
  logic                              out_ready_i = 1'b0;
  logic [dfs_pkg::FIELD_INDEX_W-1:0] field_index_o;
  logic [dfs_pkg::START_POS_W-1:0]   start_pos_o;
  logic [dfs_pkg::FIELD_LEN_W-1:0]   field_length_o;
  logic                              last_field_o;
  logic                              unclosed_quote_o;

  delimited_field_splitter DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_delimiter_i (cfg_delimiter_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .kind_i          (kind_i),
    .byte_value_i    (byte_value_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .field_index_o   (field_index_o),
    .start_pos_o     (start_pos_o),
    .field_length_o  (field_length_o),
    .last_field_o    (last_field_o),
    .unclosed_quote_o(unclosed_quote_o)
  );

  always #10 clk_i = ~clk_i;

  // predictor state
  logic [7:0]  delim_now = dfs_pkg::DELIMITER_RESET;
  int unsigned line_at = 0;
  int unsigned fields_done = 0;
  scan_e       scan = SCAN_START;
  int unsigned quote_cnt = 0;
  int unsigned keep_first = 0;
  int unsigned keep_end = 0;
  bit          has_text = 1'b0;

  dfs_pkg::result_t fields_due[$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent = 0;
  int unsigned burst_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;
  int unsigned stall_tick = 0;

  function automatic bit is_blank(logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic void keep_byte(int unsigned pos, logic [7:0] b);
    if (is_blank(b)) return;
    if (!has_text) begin
      keep_first = pos;
      has_text = 1'b1;
    end
    keep_end = pos + 1;
  endfunction

  function automatic void clear_field();
    scan = SCAN_START;
    quote_cnt = 0;
    keep_first = 0;
    keep_end = 0;
    has_text = 1'b0;
  endfunction

  function automatic void queue_field(bit last, bit unclosed);
    dfs_pkg::result_t r;
    logic [31:0]      first;
    logic [31:0]      span;
    first = 0;
    span = 0;
    if (has_text && !unclosed) begin
      first = keep_first;
      span = keep_end - keep_first;
    end
    r.field_index = fields_done[3:0];
    r.start_pos = first[dfs_pkg::START_POS_W-1:0];
    r.field_length = span[dfs_pkg::FIELD_LEN_W-1:0];
    r.last_field = last;
    r.unclosed_quote = unclosed;
    fields_due.push_back(r);
  endfunction

  // advance the splitter state by one accepted request
  function automatic void split_step(logic kind, logic [7:0] b);
    int unsigned pos;
    if (kind == dfs_pkg::KIND_END) begin
      queue_field(1'b1, scan == SCAN_QUOTED);
      line_at = 0;
      fields_done = 0;
      clear_field();
      return;
    end
    if (line_at >= dfs_pkg::LINE_BYTES) return;
    pos = line_at;
    line_at++;
    if (scan == SCAN_DONE) return;
    if (scan == SCAN_QUOTED) begin
      if (b == dfs_pkg::QUOTE_BYTE) begin
        quote_cnt++;
        if (quote_cnt >= QUOTE_LEN) begin
          quote_cnt = 0;
          scan = SCAN_AFTER;
        end
        return;
      end
      // a short run of quotes inside the quoted text is content
      if (quote_cnt != 0) begin
        if (!has_text) begin
          keep_first = pos - quote_cnt;
          has_text = 1'b1;
        end
        keep_end = pos;
        quote_cnt = 0;
      end
      keep_byte(pos, b);
      return;
    end
    if (b == delim_now) begin
      if (fields_done + 1 >= dfs_pkg::MAX_FIELDS_N) begin
        scan = SCAN_DONE;
        return;
      end
      queue_field(1'b0, 1'b0);
      fields_done++;
      clear_field();
      return;
    end
    if (scan == SCAN_AFTER) return;
    if (scan == SCAN_START) begin
      if (b == dfs_pkg::QUOTE_BYTE) begin
        keep_byte(pos, b);
        quote_cnt++;
        if (quote_cnt >= QUOTE_LEN) begin
          quote_cnt = 0;
          has_text = 1'b0;
          keep_first = 0;
          keep_end = 0;
          scan = SCAN_QUOTED;
        end
        return;
      end
      quote_cnt = 0;
      scan = SCAN_PLAIN;
    end
    keep_byte(pos, b);
  endfunction

  function automatic logic [7:0] blank_byte();
    logic [7:0] b;
    b = 8'd32;
    if ($urandom_range(0, 2) != 0) b = 8'($urandom_range(9, 13));
    return b;
  endfunction

  function automatic logic [7:0] text_byte(bit with_delim);
    int unsigned sel;
    logic [7:0]  b;
    sel = $urandom_range(0, 19);
    b = 8'($urandom_range(8'h61, 8'h7a));
    if (sel < 3) b = blank_byte();
    else if (sel < 5) b = dfs_pkg::QUOTE_BYTE;
    else if (sel < 7) b = 8'($urandom_range(0, 255));
    else if (sel < 9 && with_delim) b = delim_now;
    else if (sel == 9) b = ($urandom_range(0, 1) != 0) ? 8'h00 : 8'hff;
    return b;
  endfunction

  // one request on the input channel, bursts separated by random gaps
  task automatic send_item(logic kind, logic [7:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    kind_i <= kind;
    byte_value_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    split_step(kind, b);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_item(dfs_pkg::KIND_BYTE, s[i]);
  endtask

  task automatic end_line();
    send_item(dfs_pkg::KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (fields_due.size() != 0) @(posedge clk_i);
    // bytes can still be in the pipeline after the last result
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_delimiter(logic [7:0] v);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_delimiter_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    delim_now = v;
  endtask

  task automatic send_random_line();
    int unsigned nf;
    int unsigned sel;
    bit          open_last;
    bit          is_last;
    // broken lines: arbitrary bytes biased toward the interesting values
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(0, 30)) begin
        sel = $urandom_range(0, 5);
        if (sel == 0) send_item(dfs_pkg::KIND_BYTE, delim_now);
        else if (sel == 1) send_item(dfs_pkg::KIND_BYTE, dfs_pkg::QUOTE_BYTE);
        else if (sel == 2) send_item(dfs_pkg::KIND_BYTE, blank_byte());
        else send_item(dfs_pkg::KIND_BYTE, 8'($urandom_range(0, 255)));
      end
      end_line();
      return;
    end
    nf = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 19) : $urandom_range(1, 6);
    open_last = ($urandom_range(0, 9) == 0);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) send_item(dfs_pkg::KIND_BYTE, delim_now);
      is_last = (f == nf - 1);
      sel = $urandom_range(0, 9);
      if (open_last && is_last) sel = 5;
      if (sel < 4) begin
        repeat ($urandom_range(0, 2)) send_item(dfs_pkg::KIND_BYTE, blank_byte());
        repeat ($urandom_range(0, 8)) send_item(dfs_pkg::KIND_BYTE, text_byte(1'b0));
        repeat ($urandom_range(0, 2)) send_item(dfs_pkg::KIND_BYTE, blank_byte());
      end else if (sel < 7) begin
        // a leading blank turns the quotes into plain text
        if ($urandom_range(0, 5) == 0) send_item(dfs_pkg::KIND_BYTE, blank_byte());
        repeat (QUOTE_LEN) send_item(dfs_pkg::KIND_BYTE, dfs_pkg::QUOTE_BYTE);
        repeat ($urandom_range(0, 8)) send_item(dfs_pkg::KIND_BYTE, text_byte(1'b1));
        if (!(open_last && is_last)) begin
          repeat (QUOTE_LEN) send_item(dfs_pkg::KIND_BYTE, dfs_pkg::QUOTE_BYTE);
          repeat ($urandom_range(0, 3)) send_item(dfs_pkg::KIND_BYTE, text_byte(1'b0));
        end
      end else if (sel < 9) begin
        repeat ($urandom_range(0, 3)) send_item(dfs_pkg::KIND_BYTE, blank_byte());
      end else begin
        repeat ($urandom_range(1, 2)) send_item(dfs_pkg::KIND_BYTE, dfs_pkg::QUOTE_BYTE);
        repeat ($urandom_range(0, 4)) send_item(dfs_pkg::KIND_BYTE, text_byte(1'b0));
      end
    end
    end_line();
  endtask

  task automatic test_directed();
    // trimming, empty field, quoted field holding a delimiter, dropped tail
    send_text(" a\t,,\"\"\"p,q\"\"\"z");
    end_line();
    // line ending inside a quoted field
    send_text("\"\"\"u");
    end_line();
    send_item(dfs_pkg::KIND_BYTE, 8'h00);
    send_item(dfs_pkg::KIND_BYTE, 8'hff);
    end_line();
  endtask

  task automatic test_field_limit();
    for (int f = 0; f < 19; f++) begin
      send_text("f");
      send_item(dfs_pkg::KIND_BYTE, 8'h61 + 8'(f));
      send_item(dfs_pkg::KIND_BYTE, delim_now);
    end
    end_line();
  endtask

  task automatic test_random_lines(logic [7:0] delim, int unsigned budget);
    int unsigned first_item;
    set_delimiter(delim);
    first_item = items_sent;
    while (items_sent - first_item < budget) send_random_line();
  endtask

  task automatic check_result();
    dfs_pkg::result_t got;
    dfs_pkg::result_t want;
    got.field_index = field_index_o;
    got.start_pos = start_pos_o;
    got.field_length = field_length_o;
    got.last_field = last_field_o;
    got.unclosed_quote = unclosed_quote_o;
    if (fields_due.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("unexpected field: idx %0d start %0d len %0d last %0b open %0b",
                 got.field_index, got.start_pos, got.field_length, got.last_field,
                 got.unclosed_quote);
      return;
    end
    want = fields_due.pop_front();
    if (got.field_index !== want.field_index || got.start_pos !== want.start_pos ||
        got.field_length !== want.field_length || got.last_field !== want.last_field ||
        got.unclosed_quote !== want.unclosed_quote) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display({"field mismatch: want idx %0d start %0d len %0d last %0b open %0b, ",
                  "got idx %0d start %0d len %0d last %0b open %0b"},
                 want.field_index, want.start_pos, want.field_length, want.last_field,
                 want.unclosed_quote, got.field_index, got.start_pos, got.field_length,
                 got.last_field, got.unclosed_quote);
    end
  endtask

  // output side: check each result, stall on a changing pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) check_result();
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_ready_i <= 1'b1;
      1: out_ready_i <= 1'($urandom_range(0, 1));
      2: out_ready_i <= ($urandom_range(0, 3) == 0);
      default: out_ready_i <= (stall_tick % 8 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_field_limit();
    test_random_lines(8'd44, 200);
    test_random_lines(8'h00, 120);
    test_random_lines(8'hff, 120);
    test_random_lines(dfs_pkg::QUOTE_BYTE, 120);
    test_random_lines(8'd9, 120);
    test_random_lines(8'd32, 120);
    test_random_lines(8'($urandom_range(0, 255)), 180);
    test_random_lines(dfs_pkg::DELIMITER_RESET, 150);
    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
